// ===== rtl/spf_pkg.sv =====
// Shared types, constants and byte functions of the segment packet framer.
package spf_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  ESC_BYTE    = 8'h10;
    localparam logic [7:0]  TYPE_LAST   = 8'h30;
    localparam logic [7:0]  TYPE_ZERO   = 8'hA1;
    localparam logic [7:0]  TYPE_MID    = 8'h20;
    localparam logic [7:0]  OWNER_BYTE  = 8'h01;
    localparam logic [7:0]  TIER_HI     = 8'h7F;
    localparam logic [7:0]  TIER_LO     = 8'hFF;
    localparam logic [7:0]  MARK_BYTE   = 8'h80;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCNT_W-1:0] QUEUE_FULL_CNT = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] QUEUE_LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_HDR0   = 5'd0;
    localparam logic [POS_W-1:0] POS_DATA   = 5'd16;
    localparam logic [POS_W-1:0] POS_CRC_HI = 5'd17;
    localparam logic [POS_W-1:0] POS_CRC_LO = 5'd18;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [23:0] segment_number;
        logic [7:0]  packet_number;
        logic [15:0] packet_offset;
        logic [7:0]  type_byte;
    } spf_entry_t;

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] hdr_byte(spf_entry_t e, logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = e.segment_number[23:16];
            4'd1:    b = e.segment_number[15:8];
            4'd2:    b = e.segment_number[7:0];
            4'd3:    b = e.packet_number;
            4'd4:    b = OWNER_BYTE;
            4'd5:    b = TIER_HI;
            4'd6:    b = TIER_LO;
            4'd7:    b = TIER_LO;
            4'd8:    b = TIER_LO;
            4'd9:    b = TIER_HI;
            4'd10:   b = MARK_BYTE;
            4'd11:   b = e.type_byte;
            4'd12:   b = e.packet_number;
            4'd13:   b = 8'h00;
            4'd14:   b = e.packet_offset[15:8];
            4'd15:   b = e.packet_offset[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/spf_front.sv =====
// Front end: classify an incoming word and build its queue entry.
module spf_front (
    input  logic               [7:0]  s_data_byte,
    input  logic                      s_first_byte,
    input  logic                      s_last_byte,
    input  logic               [23:0] s_segment_number,
    input  logic               [7:0]  s_packet_number,
    input  logic               [15:0] s_packet_offset,
    input  logic                      s_last_segment,
    output spf_pkg::spf_entry_t       entry
);

    logic [7:0] type_sel;

    always_comb begin
        if (s_last_segment) begin
            type_sel = spf_pkg::TYPE_LAST;
        end else if (s_packet_number == 8'h00) begin
            type_sel = spf_pkg::TYPE_ZERO;
        end else begin
            type_sel = spf_pkg::TYPE_MID;
        end
    end

    always_comb begin
        entry.data_byte      = s_data_byte;
        entry.first_byte     = s_first_byte;
        entry.last_byte      = s_last_byte;
        entry.segment_number = s_segment_number;
        entry.packet_number  = s_packet_number;
        entry.packet_offset  = s_packet_offset;
        entry.type_byte      = type_sel;
    end

endmodule

// ===== rtl/spf_queue.sv =====
// Short entry queue between the front end and the byte sequencer.
module spf_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  spf_pkg::spf_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output spf_pkg::spf_entry_t head,
    output logic                head_valid
);

    spf_pkg::spf_entry_t               mem_reg [spf_pkg::QUEUE_DEPTH];
    logic [spf_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [spf_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [spf_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              do_push, do_pop;

    assign full       = (count_reg == spf_pkg::QUEUE_FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == spf_pkg::QUEUE_LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == spf_pkg::QUEUE_LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/spf_back.sv =====
// Back end: sequence header, payload and CRC bytes, escape 0x10, drive output word.
module spf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  spf_pkg::spf_entry_t head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_end_of_run,
    output logic                m_end_of_packet
);

    logic [15:0]              crc_reg, crc_next;
    logic [spf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                     started_reg, started_next;
    logic                     dup_reg, dup_next;
    logic                     m_valid_reg, m_valid_next;
    logic [7:0]               m_out_byte_reg, m_out_byte_next;
    logic                     m_eor_reg, m_eor_next;
    logic                     m_eop_reg, m_eop_next;

    logic                     load, fire, is_esc, item_tail, final_emit;
    logic [spf_pkg::POS_W-1:0] pos_init, pos_cur;
    logic [15:0]              crc_base, crc_fin;
    logic [7:0]               cur_byte;

    assign load     = !m_valid_reg || m_ready;
    assign fire     = head_valid && load;
    assign pos_init = head.first_byte ? spf_pkg::POS_HDR0 : spf_pkg::POS_DATA;
    assign pos_cur  = started_reg ? pos_reg : pos_init;
    assign crc_base = (pos_cur == spf_pkg::POS_HDR0) ? spf_pkg::CRC_INIT : crc_reg;
    assign crc_fin  = crc_reg ^ spf_pkg::CRC_INIT;

    always_comb begin
        if (pos_cur < spf_pkg::POS_DATA) begin
            cur_byte = spf_pkg::hdr_byte(head, pos_cur[3:0]);
        end else if (pos_cur == spf_pkg::POS_DATA) begin
            cur_byte = head.data_byte;
        end else if (pos_cur == spf_pkg::POS_CRC_HI) begin
            cur_byte = crc_fin[15:8];
        end else begin
            cur_byte = crc_fin[7:0];
        end
    end

    assign is_esc     = (cur_byte == spf_pkg::ESC_BYTE);
    assign item_tail  = (pos_cur == spf_pkg::POS_DATA && !head.last_byte) ||
                        (pos_cur == spf_pkg::POS_CRC_LO);
    assign final_emit = item_tail && (!is_esc || dup_reg);

    always_comb begin
        crc_next        = crc_reg;
        pos_next        = pos_reg;
        started_next    = started_reg;
        dup_next        = dup_reg;
        m_valid_next    = m_valid_reg;
        m_out_byte_next = m_out_byte_reg;
        m_eor_next      = m_eor_reg;
        m_eop_next      = m_eop_reg;
        pop             = 1'b0;
        if (fire) begin
            m_valid_next    = 1'b1;
            m_out_byte_next = cur_byte;
            m_eor_next      = final_emit;
            m_eop_next      = final_emit && head.last_byte;
            // fold each header and payload byte into the CRC once, not on its escape copy
            if (!dup_reg && pos_cur <= spf_pkg::POS_DATA) begin
                crc_next = spf_pkg::crc_byte(crc_base, cur_byte);
            end
            if (final_emit && pos_cur == spf_pkg::POS_CRC_LO) begin
                crc_next = spf_pkg::CRC_INIT;
            end
            if (is_esc && !dup_reg) begin
                // hold position, send the copy next
                dup_next     = 1'b1;
                started_next = 1'b1;
                pos_next     = pos_cur;
            end else begin
                dup_next = 1'b0;
                if (final_emit) begin
                    started_next = 1'b0;
                    pop          = 1'b1;
                end else begin
                    started_next = 1'b1;
                    pos_next     = pos_cur + 1'b1;
                end
            end
        end else if (load) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg        <= spf_pkg::CRC_INIT;
            pos_reg        <= '0;
            started_reg    <= 1'b0;
            dup_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_out_byte_reg <= '0;
            m_eor_reg      <= 1'b0;
            m_eop_reg      <= 1'b0;
        end else begin
            crc_reg        <= crc_next;
            pos_reg        <= pos_next;
            started_reg    <= started_next;
            dup_reg        <= dup_next;
            m_valid_reg    <= m_valid_next;
            m_out_byte_reg <= m_out_byte_next;
            m_eor_reg      <= m_eor_next;
            m_eop_reg      <= m_eop_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_out_byte_reg;
    assign m_end_of_run    = m_eor_reg;
    assign m_end_of_packet = m_eop_reg;

    a_dup_is_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        dup_reg |-> (head_valid && cur_byte == spf_pkg::ESC_BYTE))
        else $error("escape copy pending on a non-escape byte");

    a_started_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> head_valid)
        else $error("item in progress without a queue head");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> (pos_reg <= spf_pkg::POS_CRC_LO))
        else $error("byte position out of range");

    a_eop_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_eop_reg) |-> m_eor_reg)
        else $error("end of packet without end of run");

    a_crc_reset_after_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && final_emit && pos_cur == spf_pkg::POS_CRC_LO) |=>
            (crc_reg == spf_pkg::CRC_INIT))
        else $error("CRC not restarted after packet");

endmodule

// ===== rtl/segment_packet_framer.sv =====
// An accepted item is queued; its first output word is then registered in the back end.
// Throughput: one byte per cycle from the back-end sequencer while an item is queued and
//   m_ready is high; an item is 1 to 19 bytes (header 16, payload 1, CRC 2), 0x10 twice.
// A two-entry queue lets the front accept while the sequencer or the output stalls.
// Reset (synchronous, aresetn low): queue emptied, output invalid, CRC set to 0xFFFF.
// Top level of the segment packet framer.
module segment_packet_framer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    input  logic [23:0] s_segment_number,
    input  logic [7:0]  s_packet_number,
    input  logic [15:0] s_packet_offset,
    input  logic        s_last_segment,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_end_of_run,
    output logic        m_end_of_packet
);

    spf_pkg::spf_entry_t front_entry;
    spf_pkg::spf_entry_t head;
    logic                head_valid;
    logic                q_full;
    logic                pop;

    spf_front u_front (
        .s_data_byte      (s_data_byte),
        .s_first_byte     (s_first_byte),
        .s_last_byte      (s_last_byte),
        .s_segment_number (s_segment_number),
        .s_packet_number  (s_packet_number),
        .s_packet_offset  (s_packet_offset),
        .s_last_segment   (s_last_segment),
        .entry            (front_entry)
    );

    assign s_ready = !q_full;

    spf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    spf_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .head_valid      (head_valid),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_end_of_run    (m_end_of_run),
        .m_end_of_packet (m_end_of_packet)
    );

endmodule

// ===== test/tb_top.sv =====
// Testbench for the segment packet framer: line word scoreboard, stimulus tasks and top module.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 310;
    localparam int QUIET_ITEMS    = 50;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [7:0] line_val;
        logic       run_end;
        logic       pkt_end;
    } line_word_t;

    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [23:0] seg;
        logic [7:0]  pkt;
        logic [15:0] off;
        logic        last_seg;
    } payload_item_t;

    // Predicts the escaped line words of each accepted payload word and checks them in order.
    class framer_board;
        line_word_t  line_due[$];
        logic [15:0] crc_acc;
        int          mismatches;
        int          items_seen;
        int          packets_closed;
        int          words_checked;
        int          escapes_due;

        function new();
            crc_acc        = spf_pkg::CRC_INIT;
            mismatches     = 0;
            items_seen     = 0;
            packets_closed = 0;
            words_checked  = 0;
            escapes_due    = 0;
        endfunction

        // Shift one byte through the CRC register, most significant bit first.
        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int k = 7; k >= 0; k--) begin
                fb = c[15] ^ b[k];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ spf_pkg::CRC_POLY;
                end
            end
            return c;
        endfunction

        // Header as 16 bytes, first byte in the top bits.
        static function logic [127:0] header_bytes(logic [23:0] seg, logic [7:0] pkt,
                                                   logic [15:0] off, logic last_seg);
            logic [7:0] kind;
            if (last_seg) begin
                kind = spf_pkg::TYPE_LAST;
            end else if (pkt == 8'h00) begin
                kind = spf_pkg::TYPE_ZERO;
            end else begin
                kind = spf_pkg::TYPE_MID;
            end
            return {seg, pkt, spf_pkg::OWNER_BYTE, spf_pkg::TIER_HI,
                    spf_pkg::TIER_LO, spf_pkg::TIER_LO, spf_pkg::TIER_LO, spf_pkg::TIER_HI,
                    spf_pkg::MARK_BYTE, kind, pkt, 8'h00, off};
        endfunction

        function void put_word(logic [7:0] b, bit fold);
            line_word_t w;
            if (fold) begin
                crc_acc = crc_step(crc_acc, b);
            end
            w.line_val = b;
            w.run_end  = 1'b0;
            w.pkt_end  = 1'b0;
            line_due.push_back(w);
            if (b == spf_pkg::ESC_BYTE) begin
                line_due.push_back(w);
                escapes_due++;
            end
        endfunction

        function void note_item(payload_item_t it);
            logic [127:0] hdr;
            logic [15:0]  fin;
            items_seen++;
            if (it.first) begin
                crc_acc = spf_pkg::CRC_INIT;
                hdr = header_bytes(it.seg, it.pkt, it.off, it.last_seg);
                for (int i = 0; i < 16; i++) begin
                    put_word(hdr[127 - 8 * i -: 8], 1'b1);
                end
            end
            put_word(it.data, 1'b1);
            if (it.last) begin
                fin = ~crc_acc;
                put_word(fin[15:8], 1'b0);
                put_word(fin[7:0], 1'b0);
                crc_acc = spf_pkg::CRC_INIT;
                line_due[line_due.size() - 1].pkt_end = 1'b1;
                packets_closed++;
            end
            line_due[line_due.size() - 1].run_end = 1'b1;
        endfunction

        function void check_line_word(logic [7:0] b, logic run_end, logic pkt_end);
            line_word_t w;
            words_checked++;
            if (line_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("[%0t] unexpected line word %h run_end %b end_of_packet %b",
                             $time, b, run_end, pkt_end);
                end
            end else begin
                w = line_due.pop_front();
                if (w.line_val !== b || w.run_end !== run_end || w.pkt_end !== pkt_end) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] line word %0d: expected %h/%b/%b, got %h/%b/%b",
                                 $time, words_checked, w.line_val, w.run_end, w.pkt_end,
                                 b, run_end, pkt_end);
                    end
                end
            end
        endfunction
    endclass

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte      = 8'h00;
    logic        s_first_byte     = 1'b0;
    logic        s_last_byte      = 1'b0;
    logic [23:0] s_segment_number = 24'h000000;
    logic [7:0]  s_packet_number  = 8'h00;
    logic [15:0] s_packet_offset  = 16'h0000;
    logic        s_last_segment   = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_end_of_run;
    logic        m_end_of_packet;

    framer_board board;
    bit          quiet_tail = 1'b0;
    int          gap_chance = 0;
    int          idle_cycles = 0;

    segment_packet_framer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_first_byte     (s_first_byte),
        .s_last_byte      (s_last_byte),
        .s_segment_number (s_segment_number),
        .s_packet_number  (s_packet_number),
        .s_packet_offset  (s_packet_offset),
        .s_last_segment   (s_last_segment),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_end_of_run     (m_end_of_run),
        .m_end_of_packet  (m_end_of_packet)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic payload_item_t framed_item(logic [7:0] data, logic first, logic last,
                                                  logic [23:0] seg, logic [7:0] pkt,
                                                  logic [15:0] off, logic last_seg);
        payload_item_t it;
        it.data     = data;
        it.first    = first;
        it.last     = last;
        it.seg      = seg;
        it.pkt      = pkt;
        it.off      = off;
        it.last_seg = last_seg;
        return it;
    endfunction

    function automatic payload_item_t random_item(logic first, logic last);
        payload_item_t it;
        it.data     = ($urandom_range(0, 3) == 0) ? spf_pkg::ESC_BYTE : 8'($urandom);
        it.first    = first;
        it.last     = last;
        it.seg      = 24'($urandom);
        it.pkt      = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        it.off      = 16'($urandom);
        it.last_seg = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // One-word packet whose CRC carries an escape byte in the chosen half.
    function automatic payload_item_t escaped_crc_packet(bit want_hi);
        payload_item_t it;
        logic [127:0]  hdr;
        logic [15:0]   crc;
        logic [15:0]   fin;
        it = framed_item(8'h00, 1'b1, 1'b1, 24'h5AC396, 8'h2D, 16'h4E00, 1'b0);
        for (int lo = 0; lo < 256; lo++) begin
            it.off[7:0] = lo[7:0];
            hdr = framer_board::header_bytes(it.seg, it.pkt, it.off, it.last_seg);
            crc = spf_pkg::CRC_INIT;
            for (int i = 0; i < 16; i++) begin
                crc = framer_board::crc_step(crc, hdr[127 - 8 * i -: 8]);
            end
            for (int d = 0; d < 256; d++) begin
                fin = ~framer_board::crc_step(crc, d[7:0]);
                if ((want_hi ? fin[15:8] : fin[7:0]) == spf_pkg::ESC_BYTE) begin
                    it.data = d[7:0];
                    return it;
                end
            end
        end
        return it;
    endfunction

    // Hold the word until the block takes it.
    task automatic send_item(input payload_item_t it);
        s_valid          <= 1'b1;
        s_data_byte      <= it.data;
        s_first_byte     <= it.first;
        s_last_byte      <= it.last;
        s_segment_number <= it.seg;
        s_packet_number  <= it.pkt;
        s_packet_offset  <= it.off;
        s_last_segment   <= it.last_seg;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic maybe_pause();
        if (!quiet_tail && gap_chance != 0 && $urandom_range(1, gap_chance) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // Stop sending until every predicted line word has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.line_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic directed_items();
        // payload with no header continues from the idle CRC value
        send_item(framed_item(8'h00, 1'b0, 1'b0, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1));
        send_item(framed_item(spf_pkg::ESC_BYTE, 1'b0, 1'b1, 24'h000000, 8'h00, 16'h0000,
                              1'b0));
        // one-word packet, packet zero
        send_item(framed_item(8'hFF, 1'b1, 1'b1, 24'hFFFFFF, 8'h00, 16'hFFFF, 1'b0));
        // escape bytes all through the header
        send_item(framed_item(spf_pkg::ESC_BYTE, 1'b1, 1'b0, 24'h101010, 8'h10, 16'h1010,
                              1'b1));
        send_item(framed_item(8'h80, 1'b0, 1'b0, 24'h000000, 8'h00, 16'h0000, 1'b0));
        send_item(framed_item(8'h7F, 1'b0, 1'b1, 24'h000000, 8'h00, 16'h0000, 1'b0));
        send_item(framed_item(8'h00, 1'b1, 1'b0, 24'h000000, 8'h01, 16'h0000, 1'b0));
        send_item(framed_item(8'h55, 1'b0, 1'b0, 24'hFFFFFF, 8'hFF, 16'hFFFF, 1'b1));
        // restart before the packet is closed; the partial packet gets no CRC
        send_item(framed_item(8'hAA, 1'b1, 1'b0, 24'hABCDEF, 8'hFF, 16'h8001, 1'b1));
        send_item(framed_item(spf_pkg::ESC_BYTE, 1'b0, 1'b1, 24'h123456, 8'h00, 16'h0000,
                              1'b0));
        drain_results();
        send_item(framed_item(8'h01, 1'b1, 1'b1, 24'h800000, 8'h00, 16'h0001, 1'b1));
        send_item(escaped_crc_packet(1'b1));
        send_item(escaped_crc_packet(1'b0));
        // payload after a closed packet starts from a fresh CRC
        send_item(framed_item(8'h33, 1'b0, 1'b0, 24'h7FFFFF, 8'h80, 16'h7FFF, 1'b0));
        send_item(framed_item(8'hC4, 1'b0, 1'b1, 24'h000001, 8'h7F, 16'h8000, 1'b1));
    endtask

    // Mostly whole packets; some stray words and some packets cut off before their end.
    task automatic random_stream(int count);
        int sent;
        int len;
        int shape;
        sent = 0;
        while (sent < count) begin
            shape      = $urandom_range(0, 9);
            gap_chance = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
            len        = (shape == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                if (shape == 0) begin
                    send_item(random_item(1'b0, 1'($urandom_range(0, 1))));
                end else if (shape == 1) begin
                    send_item(random_item(i == 0, 1'b0));
                end else begin
                    send_item(random_item(i == 0, i == len - 1));
                end
                sent++;
                quiet_tail = (sent >= count - QUIET_ITEMS);
                if (sent == count / 2) begin
                    drain_results();
                end else begin
                    maybe_pause();
                end
            end
        end
    endtask

    initial begin : sink_pacing
        int stall_chance;
        int stretch;
        @(posedge aclk);
        forever begin
            stall_chance = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
            stretch      = $urandom_range(30, 150);
            repeat (stretch) begin
                if (!quiet_tail && stall_chance != 0 &&
                    $urandom_range(1, stall_chance) == 1) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(posedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.note_item(framed_item(s_data_byte, s_first_byte, s_last_byte,
                                            s_segment_number, s_packet_number,
                                            s_packet_offset, s_last_segment));
            end
            if (m_valid && m_ready) begin
                board.check_line_word(m_out_byte, m_end_of_run, m_end_of_packet);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        board = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_items();
        random_stream(RANDOM_ITEMS);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Run covered %0d payload words and %0d closed packets; %0d line words checked.",
                 board.items_seen, board.packets_closed, board.words_checked);
        $display("Doubled escape bytes predicted: %0d; mismatches: %0d.",
                 board.escapes_due, board.mismatches);
        if (board.mismatches == 0 && board.line_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spf_pkg.sv
rtl/spf_front.sv
rtl/spf_queue.sv
rtl/spf_back.sv
rtl/segment_packet_framer.sv
test/tb_top.sv
